// ----- hw/rtl/fwpd_pkg.sv -----
package fwpd_pkg;

   // Fixed structure of the drive.
   localparam int WHEEL_COUNT    = 4;
   localparam int GAIN_FRAC_BITS = 8;

   localparam int SPEED_W = 16;
   localparam int GAIN_W  = 16;
   localparam int DUTY_W  = 15;
   localparam int ERR_W   = SPEED_W + 1;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int SUM_W   = 32;
   localparam int ACC_W   = SUM_W + GAIN_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [DUTY_W-1:0] DUTY_LIMIT_RESET = DUTY_W'(25000);

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P     = 2'd0,
      CSR_GAIN_I     = 2'd1,
      CSR_GAIN_D     = 2'd2,
      CSR_DUTY_LIMIT = 2'd3
   } csr_index_type;

   // Shared controller settings handed to every wheel.
   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_i;
      logic [GAIN_W-1:0] gain_d;
      logic [DUTY_W-1:0] duty_limit;
   } cfg_type;

   typedef logic signed [SPEED_W-1:0] speed_type;

   // Wheels 2 and 3 of each group of four are mounted mirrored.
   function automatic logic wheel_mirrored(input int w);
      logic [1:0] m;
      m = 2'(w);
      return (m == 2'd1) || (m == 2'd2);
   endfunction

endpackage

// ----- hw/rtl/four_wheel_pid_drive.sv -----
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_ready  run flag, measured and target speed per wheel
// rsp      out        rsp_valid/rsp_ready  direction bit and duty magnitude per wheel
// csr      in         csr_we               register index and write data
//
// An accepted item is held in the input register while the PID pass for all four wheels
// runs, and moves into the result register, raising rsp_valid, once that register is empty
// or taken. One item is taken per cycle while results are taken.
// Reset clears the handshake state, the integrals, the prior errors and the gains.
// When the result is stalled, the input register holds one more item, then req_ready drops.
module four_wheel_pid_drive (
   input  logic clock,
   input  logic reset,

   input  logic req_valid,
   output logic req_ready,
   input  logic req_run,
   input  fwpd_pkg::speed_type req_speed_meas_a,
   input  fwpd_pkg::speed_type req_speed_meas_b,
   input  fwpd_pkg::speed_type req_speed_meas_c,
   input  fwpd_pkg::speed_type req_speed_meas_d,
   input  fwpd_pkg::speed_type req_speed_goal_a,
   input  fwpd_pkg::speed_type req_speed_goal_b,
   input  fwpd_pkg::speed_type req_speed_goal_c,
   input  fwpd_pkg::speed_type req_speed_goal_d,

   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_dir_a,
   output logic rsp_dir_b,
   output logic rsp_dir_c,
   output logic rsp_dir_d,
   output logic [fwpd_pkg::DUTY_W-1:0] rsp_mag_a,
   output logic [fwpd_pkg::DUTY_W-1:0] rsp_mag_b,
   output logic [fwpd_pkg::DUTY_W-1:0] rsp_mag_c,
   output logic [fwpd_pkg::DUTY_W-1:0] rsp_mag_d,

   input  logic csr_we,
   input  logic [fwpd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fwpd_pkg::CSR_DATA_W-1:0] csr_data
);
   import fwpd_pkg::*;

   cfg_type cfg_ff, cfg_in;

   logic      in_valid_ff, in_valid_in;
   logic      run_ff;
   speed_type meas_ff [WHEEL_COUNT];
   speed_type goal_ff [WHEEL_COUNT];
   speed_type req_meas [WHEEL_COUNT];
   speed_type req_goal [WHEEL_COUNT];

   logic              out_valid_ff, out_valid_in;
   logic              dir_ff [WHEEL_COUNT];
   logic [DUTY_W-1:0] mag_ff [WHEEL_COUNT];
   logic              wheel_dir [WHEEL_COUNT];
   logic [DUTY_W-1:0] wheel_mag [WHEEL_COUNT];

   logic advance, req_take, step;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:     cfg_in.gain_p     = csr_data;
            CSR_GAIN_I:     cfg_in.gain_i     = csr_data;
            CSR_GAIN_D:     cfg_in.gain_d     = csr_data;
            CSR_DUTY_LIMIT: cfg_in.duty_limit = csr_data[DUTY_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{gain_p: '0, gain_i: '0, gain_d: '0, duty_limit: DUTY_LIMIT_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_meas[0] = req_speed_meas_a;
   assign req_meas[1] = req_speed_meas_b;
   assign req_meas[2] = req_speed_meas_c;
   assign req_meas[3] = req_speed_meas_d;
   assign req_goal[0] = req_speed_goal_a;
   assign req_goal[1] = req_speed_goal_b;
   assign req_goal[2] = req_speed_goal_c;
   assign req_goal[3] = req_speed_goal_d;

   // Handshake: the result register moves when empty or taken.
   always_comb begin
      advance      = !out_valid_ff || rsp_ready;
      req_ready    = !in_valid_ff || advance;
      req_take     = req_valid && req_ready;
      step         = in_valid_ff && advance;
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? in_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (req_take) begin
         run_ff <= req_run;
         for (int w = 0; w < WHEEL_COUNT; w++) begin
            meas_ff[w] <= req_meas[w];
            goal_ff[w] <= req_goal[w];
         end
      end
   end

   // One PID unit per wheel, each with its own integral and prior error.
   for (genvar w = 0; w < WHEEL_COUNT; w++) begin : g_wheel
      fwpd_wheel u_wheel (
         .clock  (clock),
         .reset  (reset),
         .cfg    (cfg_ff),
         .mirror (wheel_mirrored(w)),
         .step   (step),
         .run    (run_ff),
         .meas   (meas_ff[w]),
         .goal   (goal_ff[w]),
         .dir    (wheel_dir[w]),
         .mag    (wheel_mag[w])
      );
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (step) begin
         for (int w = 0; w < WHEEL_COUNT; w++) begin
            dir_ff[w] <= wheel_dir[w];
            mag_ff[w] <= wheel_mag[w];
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_dir_a = dir_ff[0];
   assign rsp_dir_b = dir_ff[1];
   assign rsp_dir_c = dir_ff[2];
   assign rsp_dir_d = dir_ff[3];
   assign rsp_mag_a = mag_ff[0];
   assign rsp_mag_b = mag_ff[1];
   assign rsp_mag_c = mag_ff[2];
   assign rsp_mag_d = mag_ff[3];

endmodule

// ----- hw/rtl/fwpd_wheel.sv -----
module fwpd_wheel (
   input  logic              clock,
   input  logic              reset,
   input  fwpd_pkg::cfg_type cfg,
   input  logic              mirror,
   input  logic              step,
   input  logic              run,
   input  fwpd_pkg::speed_type meas,
   input  fwpd_pkg::speed_type goal,
   output logic              dir,
   output logic [fwpd_pkg::DUTY_W-1:0] mag
);
   import fwpd_pkg::*;

   logic signed [SUM_W-1:0] error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0] prior_error_ff, prior_error_in;

   logic signed [ERR_W-1:0]   err;
   logic signed [SUM_W:0]     sum_wide;
   logic signed [SUM_W-1:0]   sum_sat;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [GAIN_W:0]    gp, gi, gd;
   logic signed [ACC_W-1:0]   prod_p, prod_i, prod_d, acc, bias, scaled, lim_pos;
   logic signed [DUTY_W:0]    duty;
   logic                      neg;

   // Error, saturating integral and derivative.
   always_comb begin
      err      = ERR_W'(goal) - ERR_W'(meas);
      sum_wide = (SUM_W+1)'(error_sum_ff) + (SUM_W+1)'(err);
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
      diff = DIFF_W'(err) - DIFF_W'(prior_error_ff);
   end

   // Weighted sum, truncated toward zero, then clamped to the duty limit; zero when not running.
   always_comb begin
      gp      = $signed({1'b0, cfg.gain_p});
      gi      = $signed({1'b0, cfg.gain_i});
      gd      = $signed({1'b0, cfg.gain_d});
      prod_p  = ACC_W'(gp) * ACC_W'(err);
      prod_i  = ACC_W'(gi) * ACC_W'(sum_sat);
      prod_d  = ACC_W'(gd) * ACC_W'(diff);
      acc     = prod_p + prod_i + prod_d;
      bias    = acc[ACC_W-1] ? ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1) : '0;
      scaled  = (acc + bias) >>> GAIN_FRAC_BITS;
      lim_pos = $signed(ACC_W'(cfg.duty_limit));
      if (!run) begin
         duty = '0;
      end else if (scaled > lim_pos) begin
         duty = $signed({1'b0, cfg.duty_limit});
      end else if (scaled < -lim_pos) begin
         duty = -$signed({1'b0, cfg.duty_limit});
      end else begin
         duty = scaled[DUTY_W:0];
      end
      neg = duty[DUTY_W];
      dir = mirror ? neg : !neg;
      mag = neg ? DUTY_W'(-duty) : duty[DUTY_W-1:0];
   end

   // State advances only on a running item.
   always_comb begin
      error_sum_in   = error_sum_ff;
      prior_error_in = prior_error_ff;
      if (step && run) begin
         error_sum_in   = sum_sat;
         prior_error_in = err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff   <= '0;
         prior_error_ff <= '0;
      end else begin
         error_sum_ff   <= error_sum_in;
         prior_error_ff <= prior_error_in;
      end
   end

endmodule
